FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the cache tag model.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define SACM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Antecedent in one cycle, consequent in the next.
`define SACM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/sacm_pkg.sv
// Types and constants of the set-associative cache tag model.
package sacm_pkg;

  typedef logic [31:0] addr_t;
  typedef logic [2:0]  offset_t;
  typedef logic [1:0]  outcome_t;
  typedef logic [3:0]  way_t;
  typedef logic [31:0] total_t;

  localparam outcome_t OUTCOME_SKIP = 2'd0;
  localparam outcome_t OUTCOME_HIT  = 2'd1;
  localparam outcome_t OUTCOME_MISS = 2'd2;

  // Line offset limits (bits)
  localparam int OFFSET_MIN = 2;
  localparam int OFFSET_MAX = 4;
  localparam offset_t OFFSET_RESET = 3'd2;

  // Address filter
  localparam addr_t SKIP_WIN_LO = 32'h0f00_0000;
  localparam addr_t SKIP_WIN_HI = 32'h0f00_2000;
  localparam addr_t CACHED_BASE = 32'ha000_0000;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clr;     // clear one set of valid bits and pointer
    logic latch;   // capture the input beat
    logic rd;      // read the set row
    logic commit;  // update store and counters, load result
  } cmd_t;

  typedef struct packed {
    logic clr_last;  // clearing pass at its final set
  } sts_t;

endpackage

FILE: hw/rtl/sacm_if.sv
// Channel interfaces: fetch input, result output, configuration write.
interface sacm_in_if;
  import sacm_pkg::*;
  logic  valid;
  logic  ready;
  addr_t fetch_address;
  modport source (output valid, output fetch_address, input ready);
  modport sink   (input valid, input fetch_address, output ready);
endinterface

interface sacm_out_if;
  import sacm_pkg::*;
  logic     valid;
  logic     ready;
  outcome_t outcome;
  way_t     way_used;
  total_t   hit_total;
  total_t   miss_total;
  modport source (output valid, output outcome, output way_used,
                  output hit_total, output miss_total, input ready);
  modport sink   (input valid, input outcome, input way_used,
                  input hit_total, input miss_total, output ready);
endinterface

interface sacm_cfg_if;
  import sacm_pkg::*;
  logic    valid;
  logic    ready;
  offset_t line_offset_bits;
  modport source (output valid, output line_offset_bits, input ready);
  modport sink   (input valid, input line_offset_bits, output ready);
endinterface

FILE: hw/rtl/set_assoc_cache_hit_miss_model.sv
// Top level of the set-associative cache tag model with round-robin fill.
//
//  channel  dir  handshake        beat contents
//  -------  ---  ---------------  -----------------------------------------
//  in_i     in   valid / ready    fetch_address
//  out_o    out  valid / ready    outcome, way_used, hit_total, miss_total
//  cfg_i    in   valid / ready    line_offset_bits (ready is always high)
//
//  An item passes through accept, set-row read from the store, and compare
//  and commit; one item is in flight at a time, as the controller steps it.
//  A finished result sits in the output register while the next beat is
//  accepted; commit waits only if that register is still full.
//  After reset a clearing pass over all SETS = LINES/WAYS sets (16 at defaults)
//  zeroes valid bits and pointers; no input beat is taken during it.
//  Output beats hold under stall; configuration is taken at any time.
`include "assert_macros.svh"

module set_assoc_cache_hit_miss_model #(
  parameter int LINES = 64,
  parameter int WAYS  = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sacm_in_if.sink     in_i,
  sacm_out_if.source  out_o,
  sacm_cfg_if.sink    cfg_i
);
  import sacm_pkg::*;

  cmd_t ctrl_cmd;
  sts_t dp_sts;
  logic in_ready;
  logic out_valid;

  // Register write is a plain load; never stalls.
  assign cfg_i.ready = 1'b1;

  // Sequencing: clearing pass, accept, read, commit
  sacm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (ctrl_cmd),
    .sts_i       (dp_sts)
  );

  // Store, compare, replacement pointers, totals and result register
  sacm_dp #(
    .LINES (LINES),
    .WAYS  (WAYS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .sts_o        (dp_sts),
    .addr_i       (in_i.fetch_address),
    .cfg_we_i     (cfg_i.valid),
    .cfg_data_i   (cfg_i.line_offset_bits),
    .outcome_o    (out_o.outcome),
    .way_used_o   (out_o.way_used),
    .hit_total_o  (out_o.hit_total),
    .miss_total_o (out_o.miss_total)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  // One item in flight: no beat accepted right after another.
  `SACM_ASSERT_NEXT(a_one_in_flight, in_i.valid && in_ready, !in_ready)
  // A commit always presents a result on the next cycle.
  `SACM_ASSERT_NEXT(a_commit_shows, ctrl_cmd.commit, out_valid)
  // Skipped fetches report way zero.
  `SACM_ASSERT(a_skip_way, !out_valid || (out_o.outcome != OUTCOME_SKIP) ||
    (out_o.way_used == 4'd0))

endmodule

FILE: hw/rtl/sacm_ctrl.sv
// Controller state machine: clearing pass, accept, set read, commit.
module sacm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sacm_pkg::cmd_t  cmd_o,
  input  sacm_pkg::sts_t  sts_i
);
  import sacm_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
      end
      ST_DONE: begin
        cmd_o.commit = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/sacm_dp.sv
// Datapath: tag/valid/pointer store, tag compare, counters, result register.
module sacm_dp #(
  parameter int LINES = 64,
  parameter int WAYS  = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sacm_pkg::cmd_t      cmd_i,
  output sacm_pkg::sts_t      sts_o,
  input  sacm_pkg::addr_t     addr_i,
  input  logic                cfg_we_i,
  input  sacm_pkg::offset_t   cfg_data_i,
  output sacm_pkg::outcome_t  outcome_o,
  output sacm_pkg::way_t      way_used_o,
  output sacm_pkg::total_t    hit_total_o,
  output sacm_pkg::total_t    miss_total_o
);
  import sacm_pkg::*;

  localparam int SETS   = (LINES / WAYS > 0) ? LINES / WAYS : 1;
  localparam int IB     = $clog2(SETS + 1) - 1;  // floor(log2(SETS))
  localparam int SET_W  = (IB > 0) ? IB : 1;
  localparam int ADDR_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W  = 32 - OFFSET_MIN - IB;
  localparam logic [SET_W-1:0] SET_MASK = SET_W'((64'd1 << IB) - 64'd1);

  // Set store, one row per set
  logic [WAYS*TAG_W-1:0] tag_mem_q   [SETS];
  logic [WAYS-1:0]       valid_mem_q [SETS];
  logic [WAY_W-1:0]      ptr_mem_q   [SETS];

  logic [WAYS*TAG_W-1:0] rd_tags_q;
  logic [WAYS-1:0]       rd_valid_q;
  logic [WAY_W-1:0]      rd_ptr_q;

  addr_t             addr_q;
  offset_t           off_q, off_d, off_c;
  logic [ADDR_W-1:0] clr_idx_q, clr_idx_d;
  total_t            hits_q, hits_d, misses_q, misses_d;

  outcome_t outcome_q;
  way_t     way_q;
  total_t   hit_tot_q, miss_tot_q;

  logic [31:0]           shift_set, shift_tag;
  logic [4:0]            tag_sh;
  logic [SET_W-1:0]      set_idx;
  logic [ADDR_W-1:0]     row;
  logic [TAG_W-1:0]      tag_cur;
  logic                  skip;
  logic                  hit;
  logic [WAY_W-1:0]      hit_way, victim, ptr_nxt;
  logic [WAYS*TAG_W-1:0] new_tags;
  logic [WAYS-1:0]       new_valid;
  logic                  fill;

  // Clamp the configured offset
  always_comb begin
    off_c = off_q;
    if (off_q < 3'(OFFSET_MIN)) off_c = 3'(OFFSET_MIN);
    else if (off_q > 3'(OFFSET_MAX)) off_c = 3'(OFFSET_MAX);
  end

  assign shift_set = addr_q >> off_c;
  assign set_idx   = shift_set[SET_W-1:0] & SET_MASK;
  assign row       = ADDR_W'(set_idx);
  assign tag_sh    = 5'(off_c) + 5'(IB);
  assign shift_tag = addr_q >> tag_sh;
  assign tag_cur   = shift_tag[TAG_W-1:0];

  assign skip = ((addr_q >= SKIP_WIN_LO) && (addr_q < SKIP_WIN_HI)) ||
                (addr_q < CACHED_BASE);

  // Parallel compare, lowest matching way wins
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_valid_q[w] && (rd_tags_q[w*TAG_W +: TAG_W] == tag_cur)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  assign victim  = (rd_ptr_q > WAY_W'(WAYS - 1)) ? '0 : rd_ptr_q;
  assign ptr_nxt = (victim == WAY_W'(WAYS - 1)) ? '0 : victim + 1'b1;

  always_comb begin
    new_tags  = rd_tags_q;
    new_valid = rd_valid_q;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == victim) begin
        new_tags[w*TAG_W +: TAG_W] = tag_cur;
        new_valid[w]               = 1'b1;
      end
    end
  end

  assign fill = cmd_i.commit && !skip && !hit;

  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    if (cmd_i.commit && !skip) begin
      if (hit) hits_d = hits_q + 32'd1;
      else misses_d = misses_q + 32'd1;
    end
  end

  assign off_d     = cfg_we_i ? cfg_data_i : off_q;
  assign clr_idx_d = cmd_i.clr ? clr_idx_q + 1'b1 : clr_idx_q;
  assign sts_o.clr_last = (clr_idx_q == ADDR_W'(SETS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q     <= OFFSET_RESET;
      clr_idx_q <= '0;
      hits_q    <= '0;
      misses_q  <= '0;
    end else begin
      off_q     <= off_d;
      clr_idx_q <= clr_idx_d;
      hits_q    <= hits_d;
      misses_q  <= misses_d;
    end
  end

  // Store: one registered read, one write per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_tags_q  <= tag_mem_q[row];
      rd_valid_q <= valid_mem_q[row];
      rd_ptr_q   <= ptr_mem_q[row];
    end
    if (cmd_i.clr) begin
      valid_mem_q[clr_idx_q] <= '0;
      ptr_mem_q[clr_idx_q]   <= '0;
    end else if (fill) begin
      tag_mem_q[row]   <= new_tags;
      valid_mem_q[row] <= new_valid;
      ptr_mem_q[row]   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) addr_q <= addr_i;
    if (cmd_i.commit) begin
      hit_tot_q  <= hits_d;
      miss_tot_q <= misses_d;
      if (skip) begin
        outcome_q <= OUTCOME_SKIP;
        way_q     <= '0;
      end else if (hit) begin
        outcome_q <= OUTCOME_HIT;
        way_q     <= 4'(hit_way);
      end else begin
        outcome_q <= OUTCOME_MISS;
        way_q     <= 4'(victim);
      end
    end
  end

  assign outcome_o    = outcome_q;
  assign way_used_o   = way_q;
  assign hit_total_o  = hit_tot_q;
  assign miss_total_o = miss_tot_q;

endmodule
